>>> hdl/bir_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic for the bilinear resampler.
package bir_pkg;

  localparam int COORD_W   = 12;
  localparam int SRC_SZ_W  = 9;
  localparam int DST_SZ_W  = 13;
  localparam int CH_W      = 2;
  localparam int VAL_W     = 16;
  localparam int NUM_LANES = 3;
  localparam int PADDR_W   = 5;
  localparam int NUM_W     = COORD_W + SRC_SZ_W + 16;
  localparam int DIV_STEPS = NUM_W;

  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_QUERY = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHANNELS   = 3'd4;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_QUERY,
    KIND_QERR
  } kind_e;

  typedef struct packed {
    logic [SRC_SZ_W-1:0] sw;
    logic [SRC_SZ_W-1:0] sh;
    logic [DST_SZ_W-1:0] dw;
    logic [DST_SZ_W-1:0] dh;
    logic [CH_W-1:0]     nch;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VAL_W-1:0]   s0;
    logic [VAL_W-1:0]   s1;
    logic [VAL_W-1:0]   s2;
  } entry_t;

  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [15:0] w);
    logic [16:0] wn;
    logic [33:0] s;
    wn = 17'h10000 - {1'b0, w};
    s  = 34'(a * wn) + 34'(b * w) + 34'd32768;
    return s[31:16];
  endfunction

endpackage

>>> hdl/bir_if.sv
`timescale 1ns / 1ps
// Input and output channel interfaces of the resampler.
interface bir_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [15:0] sample_0;
  logic [15:0] sample_1;
  logic [15:0] sample_2;
  modport source (output valid, command, pos_x, pos_y, sample_0, sample_1, sample_2,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, sample_0, sample_1, sample_2,
                output ready);
endinterface

interface bir_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value_0;
  logic [15:0] value_1;
  logic [15:0] value_2;
  logic        range_error;
  modport source (output valid, value_0, value_1, value_2, range_error, input ready);
  modport sink (input valid, value_0, value_1, value_2, range_error, output ready);
endinterface

>>> hdl/bir_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module bir_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

>>> hdl/bir_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module bir_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [bir_pkg::NUM_W-1:0]        num_i,
  input  logic [bir_pkg::DST_SZ_W-1:0]     den_i,
  output logic                             done_o,
  output logic [bir_pkg::NUM_W-1:0]        quo_o
);
  import bir_pkg::*;

  logic [NUM_W-1:0]    num_q, num_d;
  logic [DST_SZ_W-1:0] den_q, den_d;
  logic [DST_SZ_W-1:0] rem_q, rem_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DST_SZ_W:0]   rem_sh;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, num_q[NUM_W-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DST_SZ_W'(rem_sh - {1'b0, den_q});
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DST_SZ_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

>>> hdl/bir_front.sv
`timescale 1ns / 1ps
// Front end: accept and classify beats; queue all but out-of-range loads.
module bir_front (
  bir_in_if.sink              in_i,
  input  bir_pkg::cfg_t       cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output bir_pkg::entry_t     entry_o
);
  import bir_pkg::*;

  logic in_range_load;
  logic in_range_query;

  assign in_i.ready     = !full_i;
  assign in_range_load  = ({1'b0, in_i.pos_x} < {4'b0, cfg_i.sw}) &&
                          ({1'b0, in_i.pos_y} < {4'b0, cfg_i.sh});
  assign in_range_query = ({1'b0, in_i.pos_x} < cfg_i.dw) &&
                          ({1'b0, in_i.pos_y} < cfg_i.dh);

  always_comb begin
    entry_o.x  = in_i.pos_x;
    entry_o.y  = in_i.pos_y;
    entry_o.s0 = in_i.sample_0;
    entry_o.s1 = in_i.sample_1;
    entry_o.s2 = in_i.sample_2;
    if (in_i.command == CMD_LOAD) begin
      entry_o.kind = KIND_LOAD;
    end else if (in_range_query) begin
      entry_o.kind = KIND_QUERY;
    end else begin
      entry_o.kind = KIND_QERR;
    end
    push_o = in_i.valid && !full_i &&
             ((in_i.command == CMD_QUERY) || in_range_load);
  end
endmodule

>>> hdl/bir_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue between the front and back ends.
module bir_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bir_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output bir_pkg::entry_t rdata_o
);
  import bir_pkg::*;

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

>>> hdl/bir_back.sv
`timescale 1ns / 1ps
// Back end: store loads, locate the four corners, read and blend them; flag range errors.
module bir_back #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bir_pkg::cfg_t   cfg_i,
  input  logic            empty_i,
  input  bir_pkg::entry_t head_i,
  output logic            pop_o,
  bir_out_if.source       out_o
);
  import bir_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;
  localparam int DW    = NUM_LANES * LW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_BL1  = 3'd4;
  localparam logic [2:0] S_BL2  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [AW-1:0]    addr_q [4];
  logic [DW-1:0]    corner_q [4];
  logic [15:0]      wx_q, wy_q;
  logic [VAL_W-1:0] top_q [NUM_LANES];
  logic [VAL_W-1:0] bot_q [NUM_LANES];

  logic             out_valid_q;
  logic [VAL_W-1:0] out_val_q [NUM_LANES];
  logic             out_err_q;
  logic             out_free;
  logic             out_load_ok, out_load_err;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  logic             div_start, done_x, done_y;
  logic [NUM_W-1:0] num_x, num_y, quo_x, quo_y;
  logic [DST_SZ_W-1:0] den_x, den_y;

  logic [SRC_SZ_W-1:0] sw_m1, sh_m1, x0, y0, x1, y1;

  function automatic logic [AW-1:0] pix_addr(input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] x);
    logic [2*COORD_W:0] a;
    a = (2*COORD_W+1)'({{(COORD_W+1){1'b0}}, y} * (2*COORD_W+1)'(MAX_WIDTH)) +
        (2*COORD_W+1)'(x);
    return a[AW-1:0];
  endfunction

  assign out_free = !out_valid_q || out_o.ready;
  assign sw_m1    = cfg_i.sw - 9'd1;
  assign sh_m1    = cfg_i.sh - 9'd1;

  assign num_x = ((cfg_i.sw > 9'd1) && (cfg_i.dw > 13'd1)) ?
                 {21'(head_i.x * sw_m1), 16'b0} : '0;
  assign num_y = ((cfg_i.sh > 9'd1) && (cfg_i.dh > 13'd1)) ?
                 {21'(head_i.y * sh_m1), 16'b0} : '0;
  assign den_x = (cfg_i.dw > 13'd1) ? cfg_i.dw - 13'd1 : 13'd1;
  assign den_y = (cfg_i.dh > 13'd1) ? cfg_i.dh - 13'd1 : 13'd1;

  bir_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_x), .den_i(den_x),
    .done_o(done_x), .quo_o(quo_x)
  );
  bir_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_y), .den_i(den_y),
    .done_o(done_y), .quo_o(quo_y)
  );

  bir_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign ram_wdata = {LW'(head_i.s2), LW'(head_i.s1), LW'(head_i.s0)};

  always_comb begin
    x0 = (quo_x[NUM_W-1:16] > 21'(sw_m1)) ? sw_m1 : quo_x[16 +: SRC_SZ_W];
    y0 = (quo_y[NUM_W-1:16] > 21'(sh_m1)) ? sh_m1 : quo_y[16 +: SRC_SZ_W];
    x1 = ({1'b0, x0} + 10'd1 < {1'b0, sw_m1}) ? x0 + 9'd1 : sw_m1;
    y1 = ({1'b0, y0} + 10'd1 < {1'b0, sh_m1}) ? y0 + 9'd1 : sh_m1;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = addr_q[cnt_q[1:0]];
    out_load_ok  = 1'b0;
    out_load_err = 1'b0;
    case (state_q)
      S_IDLE: begin
        ram_addr = pix_addr(head_i.y, head_i.x);
        if (!empty_i) begin
          case (head_i.kind)
            KIND_LOAD: begin
              ram_we = 1'b1;
              pop_o  = 1'b1;
            end
            KIND_QUERY: begin
              div_start = 1'b1;
              pop_o     = 1'b1;
              state_d   = S_DIV;
            end
            default: begin
              if (out_free) begin
                out_load_err = 1'b1;
                pop_o        = 1'b1;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (done_x && done_y) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        cnt_d   = '0;
        state_d = S_RD;
      end
      S_RD: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = S_BL1;
        end
      end
      S_BL1: begin
        state_d = S_BL2;
      end
      S_BL2: begin
        if (out_free) begin
          out_load_ok = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load_ok || out_load_err) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADDR) begin
      addr_q[0] <= pix_addr(12'(y0), 12'(x0));
      addr_q[1] <= pix_addr(12'(y0), 12'(x1));
      addr_q[2] <= pix_addr(12'(y1), 12'(x0));
      addr_q[3] <= pix_addr(12'(y1), 12'(x1));
      wx_q      <= quo_x[15:0];
      wy_q      <= quo_y[15:0];
    end
    if (state_q == S_RD && cnt_q != 3'd0) begin
      corner_q[2'(cnt_q - 3'd1)] <= ram_rdata;
    end
    if (state_q == S_BL1) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        top_q[k] <= blend(VAL_W'(corner_q[0][k*LW +: LW]),
                          VAL_W'(corner_q[1][k*LW +: LW]), wx_q);
        bot_q[k] <= blend(VAL_W'(corner_q[2][k*LW +: LW]),
                          VAL_W'(corner_q[3][k*LW +: LW]), wx_q);
      end
    end
    if (out_load_ok) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        out_val_q[k] <= (k < int'(cfg_i.nch)) ? blend(top_q[k], bot_q[k], wy_q) : '0;
      end
      out_err_q <= 1'b0;
    end else if (out_load_err) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        out_val_q[k] <= '0;
      end
      out_err_q <= 1'b1;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value_0     = out_val_q[0];
  assign out_o.value_1     = out_val_q[1];
  assign out_o.value_2     = out_val_q[2];
  assign out_o.range_error = out_err_q;
endmodule

>>> hdl/bilinear_image_resampler_core.sv
`timescale 1ns / 1ps
// Bilinear image resampler, align-corners, with frame store and APB registers.
//
// in_i carries command beats: a load writes one pixel (three samples) into the
// frame store at (pos_x, pos_y) and gives no result; a query names one
// destination pixel and gives one result beat on out_o. A load outside the
// source size is dropped; a query outside the destination size returns zeros
// with range_error set.
// A two-entry queue sits between the input and the processing engine, so input
// beats are taken while a result waits on out_o until the queue is full; a stalled
// out_o holds its beat and the engine waits behind it.
// A load is written to the frame store as it leaves the queue. A query leaves the
// queue and starts the two position dividers (one quotient bit per cycle), then
// passes through corner addressing, the four single-port frame store reads and
// the blend states; the engine takes the next entry only once back in idle.
// Reset clears the queue, the output and the registers to 256x256 source,
// 256x256 destination and three channels. The frame store is not cleared.
// Registers sit at byte addresses 0,4,8,12,16; write them only while idle.
module bilinear_image_resampler_core #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bir_in_if.sink                       in_i,
  bir_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bir_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bir_pkg::*;

  logic [SRC_SZ_W-1:0] src_width_q, src_height_q;
  logic [DST_SZ_W-1:0] dst_width_q, dst_height_q;
  logic [CH_W-1:0]     channel_count_q;
  logic                wr;
  logic [2:0]          idx;
  cfg_t                cfg;
  logic                push, pop, full, empty;
  entry_t              entry, head;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= 9'd256;
      src_height_q    <= 9'd256;
      dst_width_q     <= 13'd256;
      dst_height_q    <= 13'd256;
      channel_count_q <= 2'd3;
    end else if (wr) begin
      case (idx)
        REG_SRC_WIDTH:  src_width_q     <= pwdata[SRC_SZ_W-1:0];
        REG_SRC_HEIGHT: src_height_q    <= pwdata[SRC_SZ_W-1:0];
        REG_DST_WIDTH:  dst_width_q     <= pwdata[DST_SZ_W-1:0];
        REG_DST_HEIGHT: dst_height_q    <= pwdata[DST_SZ_W-1:0];
        REG_CHANNELS:   channel_count_q <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_WIDTH:  prdata = 32'(src_width_q);
      REG_SRC_HEIGHT: prdata = 32'(src_height_q);
      REG_DST_WIDTH:  prdata = 32'(dst_width_q);
      REG_DST_HEIGHT: prdata = 32'(dst_height_q);
      REG_CHANNELS:   prdata = 32'(channel_count_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.dw = dst_width_q;
    cfg.dh = dst_height_q;
    if (src_width_q == '0) begin
      cfg.sw = 9'd1;
    end else if ({4'b0, src_width_q} > 13'(MAX_WIDTH)) begin
      cfg.sw = 9'(MAX_WIDTH);
    end else begin
      cfg.sw = src_width_q;
    end
    if (src_height_q == '0) begin
      cfg.sh = 9'd1;
    end else if ({4'b0, src_height_q} > 13'(MAX_HEIGHT)) begin
      cfg.sh = 9'(MAX_HEIGHT);
    end else begin
      cfg.sh = src_height_q;
    end
    if (channel_count_q == '0) begin
      cfg.nch = 2'd1;
    end else if ({1'b0, channel_count_q} > 3'(MAX_CHANNELS)) begin
      cfg.nch = 2'(MAX_CHANNELS);
    end else begin
      cfg.nch = channel_count_q;
    end
  end

  bir_front u_front (
    .in_i, .cfg_i(cfg), .full_i(full), .push_o(push), .entry_o(entry)
  );

  bir_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(entry), .pop_i(pop),
    .full_o(full), .empty_o(empty), .rdata_o(head)
  );

  bir_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .empty_i(empty), .head_i(head), .pop_o(pop), .out_o
  );
endmodule

>>> hdl/bir_checker.sv
`timescale 1ns / 1ps
// Port checker for the resampler and its bind to the top level.
module bir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] value_0_i,
  input logic [15:0] value_1_i,
  input logic [15:0] value_2_i,
  input logic        range_error_i,
  input logic        pready_i
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_0_i) &&
    $stable(value_1_i) && $stable(value_2_i) && $stable(range_error_i))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && range_error_i |-> value_0_i == 16'd0 && value_1_i == 16'd0 &&
    value_2_i == 16'd0)
    else $error("range error beat carries nonzero values");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rst_ni) |-> !out_valid_i)
    else $error("result beat shown during reset");

  assert property (@(posedge clk_i) pready_i)
    else $error("pready dropped");
endmodule

bind bilinear_image_resampler_core bir_checker u_bir_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .value_0_i(out_o.value_0),
  .value_1_i(out_o.value_1),
  .value_2_i(out_o.value_2),
  .range_error_i(out_o.range_error),
  .pready_i(pready)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear image resampler core.
module tb_top;
  import bir_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] v0;
    logic [VAL_W-1:0] v1;
    logic [VAL_W-1:0] v2;
    logic             err;
  } pixel_result_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  bir_in_if  in_if ();
  bir_out_if out_if ();

  bilinear_image_resampler_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [SRC_SZ_W-1:0] src_w_reg, src_h_reg;
  logic [DST_SZ_W-1:0] dst_w_reg, dst_h_reg;
  logic [CH_W-1:0]     chan_reg;
  logic [47:0]         pixel_mem [int unsigned];
  pixel_result_t       pending_pixels [$];
  int                  errors;
  int                  burst_left;
  int unsigned         cyc;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned axis_pos(input longint unsigned p,
                                               input longint unsigned s,
                                               input longint unsigned d);
    if (s <= 1 || d <= 1) return 0;
    return ((p * (s - 1)) << 16) / (d - 1);
  endfunction

  function automatic longint unsigned mix_q16(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned w);
    return (a * (65536 - w) + b * w + 32768) >> 16;
  endfunction

  function automatic void corners(input int unsigned x, input int unsigned y,
                                  output int unsigned a[4],
                                  output longint unsigned wx, wy);
    int unsigned sw, sh;
    longint unsigned fx, fy, x0, y0, x1, y1;
    sw = eff_size(src_w_reg, 256);
    sh = eff_size(src_h_reg, 256);
    fx = axis_pos(x, sw, dst_w_reg);
    fy = axis_pos(y, sh, dst_h_reg);
    x0 = fx >> 16;
    y0 = fy >> 16;
    wx = fx & 16'hFFFF;
    wy = fy & 16'hFFFF;
    if (x0 > sw - 1) x0 = sw - 1;
    if (y0 > sh - 1) y0 = sh - 1;
    x1 = (x0 + 1 < sw - 1) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh - 1) ? y0 + 1 : sh - 1;
    a[0] = y0 * 256 + x0;
    a[1] = y0 * 256 + x1;
    a[2] = y1 * 256 + x0;
    a[3] = y1 * 256 + x1;
  endfunction

  function automatic bit query_in_range(input int unsigned x, input int unsigned y);
    return x < dst_w_reg && y < dst_h_reg;
  endfunction

  function automatic pixel_result_t interpolate(input int unsigned x, input int unsigned y);
    pixel_result_t r;
    int unsigned a[4];
    longint unsigned wx, wy, top, bot;
    logic [47:0] p[4];
    logic [15:0] lane[3];
    int unsigned nch;
    r = '{default: '0};
    if (!query_in_range(x, y)) begin
      r.err = 1'b1;
      return r;
    end
    corners(x, y, a, wx, wy);
    nch = eff_size(chan_reg, 3);
    for (int i = 0; i < 4; i++) p[i] = pixel_mem.exists(a[i]) ? pixel_mem[a[i]] : 48'd0;
    for (int k = 0; k < 3; k++) begin
      lane[k] = '0;
      if (k < nch) begin
        top = mix_q16(p[0][16*k +: 16], p[1][16*k +: 16], wx);
        bot = mix_q16(p[2][16*k +: 16], p[3][16*k +: 16], wx);
        lane[k] = 16'(mix_q16(top, bot, wy));
      end
    end
    r.v0 = lane[0];
    r.v1 = lane[1];
    r.v2 = lane[2];
    return r;
  endfunction

  task automatic send_beat(input logic cmd, input int unsigned x, input int unsigned y,
                           input logic [15:0] s0, s1, s2);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.pos_x    <= 12'(x);
    in_if.pos_y    <= 12'(y);
    in_if.sample_0 <= s0;
    in_if.sample_1 <= s1;
    in_if.sample_2 <= s2;
    do @(posedge clk); while (!in_if.ready);
    if (cmd == CMD_LOAD) begin
      if (x < eff_size(src_w_reg, 256) && y < eff_size(src_h_reg, 256))
        pixel_mem[y * 256 + x] = {s2, s1, s0};
    end else begin
      pending_pixels.push_back(interpolate(x, y));
    end
  endtask

  task automatic load_pixel(input int unsigned x, input int unsigned y);
    send_beat(CMD_LOAD, x, y, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // fill any unwritten corner before the query reads it
  task automatic query_pixel(input int unsigned x, input int unsigned y);
    int unsigned a[4];
    longint unsigned wx, wy;
    if (query_in_range(x, y)) begin
      corners(x, y, a, wx, wy);
      for (int i = 0; i < 4; i++)
        if (!pixel_mem.exists(a[i])) load_pixel(a[i] % 256, a[i] / 256);
    end
    send_beat(CMD_QUERY, x, y, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  src_w_reg = SRC_SZ_W'(value);
      REG_SRC_HEIGHT: src_h_reg = SRC_SZ_W'(value);
      REG_DST_WIDTH:  dst_w_reg = DST_SZ_W'(value);
      REG_DST_HEIGHT: dst_h_reg = DST_SZ_W'(value);
      REG_CHANNELS:   chan_reg  = CH_W'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned sw, sh, dw, dh, ch);
    settle();
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_CHANNELS, ch);
  endtask

  task automatic test_directed();
    send_beat(CMD_LOAD, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_LOAD, 1, 0, 16'h0000, 16'h0000, 16'h0000);
    send_beat(CMD_LOAD, 0, 1, 16'hFFFF, 16'h0000, 16'h8000);
    send_beat(CMD_LOAD, 1, 1, 16'h0001, 16'h7FFF, 16'hAAAA);
    send_beat(CMD_LOAD, 4095, 4095, 16'h5555, 16'h5555, 16'h5555);
    send_beat(CMD_LOAD, 256, 3, 16'h1234, 16'h1234, 16'h1234);
    query_pixel(0, 0);
    query_pixel(1, 1);
    query_pixel(255, 255);
    query_pixel(255, 0);
    query_pixel(0, 255);
    query_pixel(256, 0);
    query_pixel(0, 256);
    query_pixel(4095, 4095);
    configure(2, 2, 3, 3, 3);
    query_pixel(1, 1);
    query_pixel(2, 2);
    configure(0, 0, 0, 5, 0);
    query_pixel(0, 0);
    configure(511, 300, 4096, 1, 3);
    query_pixel(4095, 0);
    query_pixel(2048, 0);
    query_pixel(0, 1);
  endtask

  task automatic random_phase(input int n);
    int unsigned r, xmax, ymax;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      xmax = (dst_w_reg == 0) ? 0 : ((dst_w_reg > 4096) ? 4095 : dst_w_reg - 1);
      ymax = (dst_h_reg == 0) ? 0 : ((dst_h_reg > 4096) ? 4095 : dst_h_reg - 1);
      if (r < 55)
        query_pixel($urandom_range(0, xmax), $urandom_range(0, ymax));
      else if (r < 65)
        query_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      else if (r < 90)
        load_pixel($urandom_range(0, eff_size(src_w_reg, 256) - 1),
                   $urandom_range(0, eff_size(src_h_reg, 256) - 1));
      else
        load_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  task automatic test_config_sweep();
    configure(256, 256, 256, 256, 3);
    random_phase(80);
    configure(8, 6, 23, 17, 3);
    random_phase(100);
    configure(1, 1, 9, 9, 1);
    random_phase(50);
    configure(5, 7, 1, 4096, 2);
    random_phase(70);
    configure(0, 3, 4096, 0, 0);
    random_phase(50);
    configure(16, 16, 8191, 4095, 3);
    random_phase(80);
    configure(4, 4, 4, 4, 2);
    random_phase(85);
    configure(256, 2, 100, 2, 1);
    random_phase(70);
    configure(300, 511, 2, 4096, 3);
    random_phase(70);
    configure(3, 200, 7, 13, 3);
    random_phase(85);
    configure(10, 10, 5, 3, 3);
    random_phase(80);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      cyc <= 0;
    end else begin
      pixel_result_t exp_px;
      cyc <= cyc + 1;
      case ((cyc / 300) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= (cyc % 9 < 2);
        default: out_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
      if (out_if.valid && out_if.ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result beat v0=%h v1=%h v2=%h err=%b", $time,
                   out_if.value_0, out_if.value_1, out_if.value_2, out_if.range_error);
          errors++;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_if.value_0 !== exp_px.v0 || out_if.value_1 !== exp_px.v1 ||
              out_if.value_2 !== exp_px.v2 || out_if.range_error !== exp_px.err) begin
            $display("%0t: mismatch expected %h %h %h err=%b, actual %h %h %h err=%b",
                     $time, exp_px.v0, exp_px.v1, exp_px.v2, exp_px.err,
                     out_if.value_0, out_if.value_1, out_if.value_2,
                     out_if.range_error);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clk = 1'b0;
    errors = 0;
    burst_left = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CMD_LOAD;
    in_if.pos_x <= '0;
    in_if.pos_y <= '0;
    in_if.sample_0 <= '0;
    in_if.sample_1 <= '0;
    in_if.sample_2 <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    src_w_reg = 256;
    src_h_reg = 256;
    dst_w_reg = 256;
    dst_h_reg = 256;
    chan_reg = 3;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    settle();
    if (pending_pixels.size() == 0 && errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
